### sv/sixel_cell_bitmap_plotter_defines.svh
// assertion macros shared by the sixel cell bitmap plotter rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef SIXEL_CELL_BITMAP_PLOTTER_DEFINES_SVH
`define SIXEL_CELL_BITMAP_PLOTTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define SCBP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbp same-cycle check failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define SCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbp next-cycle check failed");
`else
`define SCBP_ASSERT_IMPL(label, ante, cons)
`define SCBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/scbp_pkg.sv
// types, constants and helpers for the sixel cell bitmap plotter
// no dependencies; used by the interfaces, the divider and the top level
package scbp_pkg;

    // default geometry
    localparam int CELL_WIDTH_DEF  = 8;
    localparam int CELL_HEIGHT_DEF = 12;
    localparam int SCREEN_COLS_DEF = 16;
    localparam int SCREEN_ROWS_DEF = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int XPOS_W  = 8;
    localparam int YPOS_W  = 7;
    localparam int CCOL_W  = 4;
    localparam int CROW_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int SIXEL_W = 6;

    // internal coordinate widths, sized for the largest geometry
    localparam int POS_W = 6;
    localparam int SLC_W = 4;
    localparam int GRP_W = 2;
    localparam int BIT_W = 3;

    // shared divide unit widths: dividend, divisor, step counter
    localparam int DIV_W = 8;
    localparam int DVS_W = 5;
    localparam int CNT_W = 2;

    // reciprocal scaling, exact quotients for any 8-bit dividend and divisor up to 24
    localparam int RCP_SHIFT = 16;
    localparam int RCP_W     = 17;
    localparam int RCP_ONE   = 1 << RCP_SHIFT;

    // rows in one sixel group
    localparam int GROUP_ROWS = 6;

    // output character codes
    localparam logic [CHAR_W-1:0] SIXEL_BIAS = 7'h3F;
    localparam logic [CHAR_W-1:0] GROUP_SEP  = 7'h2F;
    localparam logic [CHAR_W-1:0] CELL_END   = 7'h3B;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PLOT  = 2'd1,
        CMD_READ  = 2'd2
    } scbp_cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_DIVR,
        S_ADR1,
        S_ADR2,
        S_ADR3,
        S_PRD,
        S_PWR,
        S_RRD,
        S_REMIT,
        S_RSEP,
        S_REND
    } scbp_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [RCP_W-1:0] recip;
    } scbp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } scbp_div_rsp_t;

    // one-hot mask of a pixel row inside its group
    function automatic logic [SIXEL_W-1:0] row_bit(input logic [BIT_W-1:0] idx);
        logic [SIXEL_W-1:0] mask;
        begin
            case (idx)
                3'd0:    mask = 6'h01;
                3'd1:    mask = 6'h02;
                3'd2:    mask = 6'h04;
                3'd3:    mask = 6'h08;
                3'd4:    mask = 6'h10;
                3'd5:    mask = 6'h20;
                default: mask = 6'h00;
            endcase
            return mask;
        end
    endfunction

endpackage

### sv/scbp_if.sv
// command and character channels of the sixel cell bitmap plotter
// depends on scbp_pkg for field widths
interface scbp_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [scbp_pkg::CMD_W-1:0]   cmd;
    logic [scbp_pkg::XPOS_W-1:0]  x_pos;
    logic [scbp_pkg::YPOS_W-1:0]  y_pos;
    logic [scbp_pkg::CCOL_W-1:0]  cell_col;
    logic [scbp_pkg::CROW_W-1:0]  cell_row;

    modport source (output valid, cmd, x_pos, y_pos, cell_col, cell_row, input ready);
    modport sink   (input valid, cmd, x_pos, y_pos, cell_col, cell_row, output ready);
endinterface

interface scbp_char_if;
    logic                         valid;
    logic                         ready;
    logic [scbp_pkg::CHAR_W-1:0]  char_code;
    logic                         last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

### sv/scbp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module scbp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 2048
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/scbp_div.sv
// shared divide unit by a constant: reciprocal multiply for the quotient, then
// multiply back and subtract for the remainder; depends on scbp_pkg and the assertion header
`include "sixel_cell_bitmap_plotter_defines.svh"

module scbp_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scbp_pkg::scbp_div_req_t req,
    output scbp_pkg::scbp_div_rsp_t rsp
);

    localparam logic [scbp_pkg::CNT_W-1:0] STEP_QUOT = scbp_pkg::CNT_W'(2);
    localparam logic [scbp_pkg::CNT_W-1:0] STEP_REM  = scbp_pkg::CNT_W'(1);

    logic [scbp_pkg::DIV_W-1:0]               dvd_reg;
    logic [scbp_pkg::DIV_W-1:0]               dvd_next;
    logic [scbp_pkg::DIV_W-1:0]               quot_reg;
    logic [scbp_pkg::DIV_W-1:0]               quot_next;
    logic [scbp_pkg::DVS_W-1:0]               rem_reg;
    logic [scbp_pkg::DVS_W-1:0]               rem_next;
    logic [scbp_pkg::DVS_W-1:0]               dvs_reg;
    logic [scbp_pkg::DVS_W-1:0]               dvs_next;
    logic [scbp_pkg::RCP_W-1:0]               rcp_reg;
    logic [scbp_pkg::RCP_W-1:0]               rcp_next;
    logic [scbp_pkg::CNT_W-1:0]               cnt_reg;
    logic [scbp_pkg::CNT_W-1:0]               cnt_next;
    logic                                     done_reg;
    logic                                     done_next;
    logic                                     busy;
    logic [scbp_pkg::DIV_W-1:0]               mul_a;
    logic [scbp_pkg::RCP_W-1:0]               mul_b;
    logic [scbp_pkg::DIV_W+scbp_pkg::RCP_W-1:0] prod;
    logic [scbp_pkg::DIV_W-1:0]               rem_full;

    assign busy = (cnt_reg != '0);

    // one multiplier: dividend times reciprocal, then quotient times divisor
    assign mul_a    = (cnt_reg == STEP_REM) ? quot_reg : dvd_reg;
    assign mul_b    = (cnt_reg == STEP_REM) ? scbp_pkg::RCP_W'(dvs_reg) : rcp_reg;
    assign prod     = {{scbp_pkg::RCP_W{1'b0}}, mul_a} * {{scbp_pkg::DIV_W{1'b0}}, mul_b};
    assign rem_full = dvd_reg - prod[scbp_pkg::DIV_W-1:0];

    // step sequencing
    always_comb
    begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rcp_next  = rcp_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rcp_next = req.recip;
            cnt_next = STEP_QUOT;
        end
        else if (cnt_reg == STEP_QUOT)
        begin
            quot_next = prod[scbp_pkg::RCP_SHIFT +: scbp_pkg::DIV_W];
            cnt_next  = cnt_reg - 1'b1;
        end
        else if (cnt_reg == STEP_REM)
        begin
            rem_next  = rem_full[scbp_pkg::DVS_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        rcp_reg  <= rcp_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    // checks
    `SCBP_ASSERT_IMPL(a_rem_below_divisor, done_reg, rem_reg < dvs_reg)
    `SCBP_ASSERT_IMPL(a_done_when_finished, done_reg, !busy)
    `SCBP_ASSERT_IMPL(a_no_restart_busy, req.start, !busy)
    `SCBP_ASSERT_NEXT(a_start_loads_count, req.start, cnt_reg == STEP_QUOT)

endmodule

### sv/sixel_cell_bitmap_plotter.sv
// top level of the sixel cell bitmap plotter: sequencer, address math, output register
// depends on scbp_pkg, scbp_if, scbp_ram, scbp_div and the assertion header

// The plotter keeps a monochrome bitmap of character cells in one memory of
// 6-bit sixel slices and takes one command at a time. After reset, and after
// every clear command, it sweeps the memory writing zeros, one entry per
// cycle (all SCREEN_COLS*SCREEN_ROWS*ceil(CELL_HEIGHT/6)*CELL_WIDTH entries,
// 2048 at the default geometry), and takes no command during the sweep. A
// plot runs three divisions on the shared reciprocal-multiply unit (column,
// row, group), each as a quotient product, a remainder product and a done
// strobe, then three steps of address math and a read-modify-write of the
// memory (read, then write). A cell read takes the three address steps, then
// for each slice a memory read and then a character out, a separator after
// every group but the last and a closing semicolon; the character channel
// can stall each character out. Off-screen plots and reads and the unused
// command code are dropped without leaving the idle state.
`include "sixel_cell_bitmap_plotter_defines.svh"

module sixel_cell_bitmap_plotter #(
    parameter int CELL_WIDTH  = scbp_pkg::CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = scbp_pkg::CELL_HEIGHT_DEF,
    parameter int SCREEN_COLS = scbp_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = scbp_pkg::SCREEN_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    scbp_cmd_if.sink    cmds,
    scbp_char_if.source chars
);

    localparam int GROUP_COUNT = (CELL_HEIGHT + scbp_pkg::GROUP_ROWS - 1) / scbp_pkg::GROUP_ROWS;
    localparam int STORE_DEPTH = SCREEN_COLS * SCREEN_ROWS * GROUP_COUNT * CELL_WIDTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int X_LIMIT     = SCREEN_COLS * CELL_WIDTH;
    localparam int Y_LIMIT     = SCREEN_ROWS * CELL_HEIGHT;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // scaled reciprocals of the three constant divisors
    localparam logic [scbp_pkg::RCP_W-1:0] RCP_X =
        scbp_pkg::RCP_W'((scbp_pkg::RCP_ONE + CELL_WIDTH - 1) / CELL_WIDTH);
    localparam logic [scbp_pkg::RCP_W-1:0] RCP_Y =
        scbp_pkg::RCP_W'((scbp_pkg::RCP_ONE + CELL_HEIGHT - 1) / CELL_HEIGHT);
    localparam logic [scbp_pkg::RCP_W-1:0] RCP_G =
        scbp_pkg::RCP_W'((scbp_pkg::RCP_ONE + scbp_pkg::GROUP_ROWS - 1)
                         / scbp_pkg::GROUP_ROWS);

    // sequencer state
    scbp_pkg::scbp_state_t state_reg;
    scbp_pkg::scbp_state_t state_next;

    // working registers
    logic [ADDR_W-1:0]                addr_reg;
    logic [ADDR_W-1:0]                addr_next;
    logic [scbp_pkg::YPOS_W-1:0]      y_reg;
    logic [scbp_pkg::YPOS_W-1:0]      y_next;
    logic [scbp_pkg::POS_W-1:0]       row_reg;
    logic [scbp_pkg::POS_W-1:0]       row_next;
    logic [scbp_pkg::POS_W-1:0]       col_reg;
    logic [scbp_pkg::POS_W-1:0]       col_next;
    logic [scbp_pkg::GRP_W-1:0]       grp_reg;
    logic [scbp_pkg::GRP_W-1:0]       grp_next;
    logic [scbp_pkg::SLC_W-1:0]       slc_reg;
    logic [scbp_pkg::SLC_W-1:0]       slc_next;
    logic [scbp_pkg::BIT_W-1:0]       bit_reg;
    logic [scbp_pkg::BIT_W-1:0]       bit_next;
    logic                             plot_reg;
    logic                             plot_next;

    // output register
    logic                             out_valid_reg;
    logic [scbp_pkg::CHAR_W-1:0]      char_reg;
    logic                             last_reg;

    // control and datapath wires
    logic                             accept;
    logic                             plot_ok;
    logic                             read_ok;
    logic                             can_load;
    logic                             last_slc;
    logic                             last_grp;
    logic                             emit;
    logic [scbp_pkg::CHAR_W-1:0]      emit_char;
    logic                             emit_last;
    logic                             ram_wr_en;
    logic [scbp_pkg::SIXEL_W-1:0]     ram_wr_data;
    logic                             ram_rd_en;
    logic [scbp_pkg::SIXEL_W-1:0]     ram_rd_data;
    scbp_pkg::scbp_div_req_t          div_req;
    scbp_pkg::scbp_div_rsp_t          div_rsp;

    // request qualification
    assign cmds.ready = (state_reg == scbp_pkg::S_IDLE);
    assign accept     = cmds.valid && cmds.ready;
    assign plot_ok    = (32'(cmds.x_pos) < 32'(X_LIMIT)) && (32'(cmds.y_pos) < 32'(Y_LIMIT));
    assign read_ok    = (32'(cmds.cell_col) < 32'(SCREEN_COLS))
                     && (32'(cmds.cell_row) < 32'(SCREEN_ROWS));
    assign can_load   = !out_valid_reg || chars.ready;
    assign last_slc   = (slc_reg == scbp_pkg::SLC_W'(CELL_WIDTH - 1));
    assign last_grp   = (grp_reg == scbp_pkg::GRP_W'(GROUP_COUNT - 1));

    // shared divide unit
    scbp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sixel store
    scbp_ram #(
        .WIDTH (scbp_pkg::SIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scbp_pkg::S_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = scbp_pkg::S_IDLE;
                end
            end
            scbp_pkg::S_IDLE:
            begin
                if (cmds.valid)
                begin
                    case (cmds.cmd)
                        scbp_pkg::CMD_CLEAR: state_next = scbp_pkg::S_CLEAR;
                        scbp_pkg::CMD_PLOT:
                            state_next = plot_ok ? scbp_pkg::S_DIVX : scbp_pkg::S_IDLE;
                        scbp_pkg::CMD_READ:
                            state_next = read_ok ? scbp_pkg::S_ADR1 : scbp_pkg::S_IDLE;
                        default:             state_next = scbp_pkg::S_IDLE;
                    endcase
                end
            end
            scbp_pkg::S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    state_next = scbp_pkg::S_DIVY;
                end
            end
            scbp_pkg::S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    state_next = scbp_pkg::S_DIVR;
                end
            end
            scbp_pkg::S_DIVR:
            begin
                if (div_rsp.done)
                begin
                    state_next = scbp_pkg::S_ADR1;
                end
            end
            scbp_pkg::S_ADR1: state_next = scbp_pkg::S_ADR2;
            scbp_pkg::S_ADR2: state_next = scbp_pkg::S_ADR3;
            scbp_pkg::S_ADR3: state_next = plot_reg ? scbp_pkg::S_PRD : scbp_pkg::S_RRD;
            scbp_pkg::S_PRD:  state_next = scbp_pkg::S_PWR;
            scbp_pkg::S_PWR:  state_next = scbp_pkg::S_IDLE;
            scbp_pkg::S_RRD:  state_next = scbp_pkg::S_REMIT;
            scbp_pkg::S_REMIT:
            begin
                if (can_load)
                begin
                    if (last_slc && last_grp)
                    begin
                        state_next = scbp_pkg::S_REND;
                    end
                    else if (last_slc)
                    begin
                        state_next = scbp_pkg::S_RSEP;
                    end
                    else
                    begin
                        state_next = scbp_pkg::S_RRD;
                    end
                end
            end
            scbp_pkg::S_RSEP:
            begin
                if (can_load)
                begin
                    state_next = scbp_pkg::S_RRD;
                end
            end
            scbp_pkg::S_REND:
            begin
                if (can_load)
                begin
                    state_next = scbp_pkg::S_IDLE;
                end
            end
            default: state_next = scbp_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: memory, divider and character strobes
    always_comb
    begin
        ram_wr_en        = 1'b0;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = cmds.x_pos;
        div_req.divisor  = scbp_pkg::DVS_W'(CELL_WIDTH);
        div_req.recip    = RCP_X;
        emit             = 1'b0;
        emit_char        = scbp_pkg::SIXEL_BIAS;
        emit_last        = 1'b0;
        case (state_reg)
            scbp_pkg::S_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            scbp_pkg::S_IDLE:
            begin
                div_req.start = accept && (cmds.cmd == scbp_pkg::CMD_PLOT) && plot_ok;
            end
            scbp_pkg::S_DIVX:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = scbp_pkg::DIV_W'(y_reg);
                div_req.divisor  = scbp_pkg::DVS_W'(CELL_HEIGHT);
                div_req.recip    = RCP_Y;
            end
            scbp_pkg::S_DIVY:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = scbp_pkg::DIV_W'(div_rsp.rem);
                div_req.divisor  = scbp_pkg::DVS_W'(scbp_pkg::GROUP_ROWS);
                div_req.recip    = RCP_G;
            end
            scbp_pkg::S_PRD:
            begin
                ram_rd_en = 1'b1;
            end
            scbp_pkg::S_PWR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data | scbp_pkg::row_bit(bit_reg);
            end
            scbp_pkg::S_RRD:
            begin
                ram_rd_en = 1'b1;
            end
            scbp_pkg::S_REMIT:
            begin
                emit      = can_load;
                emit_char = scbp_pkg::SIXEL_BIAS + scbp_pkg::CHAR_W'(ram_rd_data);
            end
            scbp_pkg::S_RSEP:
            begin
                emit      = can_load;
                emit_char = scbp_pkg::GROUP_SEP;
            end
            scbp_pkg::S_REND:
            begin
                emit      = can_load;
                emit_char = scbp_pkg::CELL_END;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // working register updates
    always_comb
    begin
        addr_next = addr_reg;
        y_next    = y_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        grp_next  = grp_reg;
        slc_next  = slc_reg;
        bit_next  = bit_reg;
        plot_next = plot_reg;
        case (state_reg)
            scbp_pkg::S_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
            end
            scbp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    y_next    = cmds.y_pos;
                    addr_next = '0;
                    row_next  = scbp_pkg::POS_W'(cmds.cell_row);
                    col_next  = scbp_pkg::POS_W'(cmds.cell_col);
                    grp_next  = '0;
                    slc_next  = '0;
                    plot_next = (cmds.cmd == scbp_pkg::CMD_PLOT);
                end
            end
            scbp_pkg::S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    col_next = scbp_pkg::POS_W'(div_rsp.quot);
                    slc_next = scbp_pkg::SLC_W'(div_rsp.rem);
                end
            end
            scbp_pkg::S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    row_next = scbp_pkg::POS_W'(div_rsp.quot);
                end
            end
            scbp_pkg::S_DIVR:
            begin
                if (div_rsp.done)
                begin
                    grp_next = scbp_pkg::GRP_W'(div_rsp.quot);
                    bit_next = scbp_pkg::BIT_W'(div_rsp.rem);
                end
            end
            // cell index, then group, then slice
            scbp_pkg::S_ADR1:
            begin
                addr_next = ADDR_W'(32'(row_reg) * 32'(SCREEN_COLS) + 32'(col_reg));
            end
            scbp_pkg::S_ADR2:
            begin
                addr_next = ADDR_W'(32'(addr_reg) * 32'(GROUP_COUNT) + 32'(grp_reg));
            end
            scbp_pkg::S_ADR3:
            begin
                addr_next = ADDR_W'(32'(addr_reg) * 32'(CELL_WIDTH) + 32'(slc_reg));
            end
            // slices of a cell are contiguous, so the address just counts
            scbp_pkg::S_REMIT:
            begin
                if (can_load)
                begin
                    addr_next = addr_reg + 1'b1;
                    if (last_slc)
                    begin
                        slc_next = '0;
                        grp_next = grp_reg + 1'b1;
                    end
                    else
                    begin
                        slc_next = slc_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scbp_pkg::S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        grp_reg  <= grp_next;
        slc_reg  <= slc_next;
        bit_reg  <= bit_next;
        plot_reg <= plot_next;
        if (emit)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

    assign chars.valid     = out_valid_reg;
    assign chars.char_code = char_reg;
    assign chars.last      = last_reg;

    // checks
    `SCBP_ASSERT_IMPL(a_store_write_state, ram_wr_en,
        (state_reg == scbp_pkg::S_CLEAR) || (state_reg == scbp_pkg::S_PWR))
    `SCBP_ASSERT_IMPL(a_div_done_state, div_rsp.done,
        (state_reg == scbp_pkg::S_DIVX) || (state_reg == scbp_pkg::S_DIVY)
        || (state_reg == scbp_pkg::S_DIVR))
    `SCBP_ASSERT_NEXT(a_end_closes_read, (state_reg == scbp_pkg::S_REND) && can_load,
        (state_reg == scbp_pkg::S_IDLE) && out_valid_reg && last_reg
        && (char_reg == scbp_pkg::CELL_END))
    `SCBP_ASSERT_IMPL(a_slice_char_floor,
        out_valid_reg && !last_reg && (char_reg != scbp_pkg::GROUP_SEP),
        char_reg >= scbp_pkg::SIXEL_BIAS)

endmodule
